// ===== hw/rtl/running_mean_stdev_accumulator_top_assert.svh =====
// Assertion macros shared by the running mean and deviation accumulator modules.
`ifndef RUNNING_MEAN_STDEV_ACCUMULATOR_TOP_ASSERT_SVH
`define RUNNING_MEAN_STDEV_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RMSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RMSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmsa_pkg.sv =====
// Shared constants, types and command bundles of the running mean and deviation accumulator.
`default_nettype none

package rmsa_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int FRAC_BITS      = 8;
  localparam int COUNT_WIDTH    = 32;
  localparam int SUM_WIDTH      = 48;
  localparam int SQ_WIDTH       = 64;
  localparam int OQ_WIDTH       = 63;
  localparam int ACT_WIDTH      = 2;
  localparam int MEAN_WIDTH     = SAMPLE_WIDTH + FRAC_BITS;
  localparam int VSQ_WIDTH      = 2 * SAMPLE_WIDTH;
  localparam int MSQ_WIDTH      = 2 * MEAN_WIDTH;

  // Dividend width: square sum scaled by 2^(2*FRAC_BITS)
  localparam int DIVN_WIDTH     = SQ_WIDTH + 2 * FRAC_BITS;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES     = DIVN_WIDTH / DIV_RADIX_BITS;
  localparam int SQRT_CYCLES    = DIVN_WIDTH / 2;
  localparam int CNT_WIDTH      = $clog2((DIV_CYCLES > SQRT_CYCLES) ? DIV_CYCLES : SQRT_CYCLES);

  localparam logic [MEAN_WIDTH-1:0] MEAN_POS_MAX = {1'b0, {(MEAN_WIDTH-1){1'b1}}};
  localparam logic [MEAN_WIDTH-1:0] MEAN_NEG_MAG = {1'b1, {(MEAN_WIDTH-1){1'b0}}};
  localparam logic [MEAN_WIDTH-1:0] STDEV_MAX    = {MEAN_WIDTH{1'b1}};
  localparam logic [DIVN_WIDTH-1:0] SQRT_BIT_INIT = {2'b01, {(DIVN_WIDTH-2){1'b0}}};

  typedef enum logic [ACT_WIDTH-1:0] {
    ACT_ADD     = 2'd0,
    ACT_DROP    = 2'd1,
    ACT_MERGE   = 2'd2,
    ACT_EXCLUDE = 2'd3
  } action_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic update;
    logic prep;
    logic div_step;
    logic mean_fix;
    logic mul;
    logic vsub;
    logic sqrt_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmsa_in_if.sv =====
// Input request channel: valid/ready handshake with the operation payload.
`default_nettype none

interface rmsa_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [rmsa_pkg::ACT_WIDTH-1:0]            action;
  logic signed [rmsa_pkg::SAMPLE_WIDTH-1:0]  sample_value;
  logic [rmsa_pkg::COUNT_WIDTH-1:0]          other_count;
  logic signed [rmsa_pkg::SUM_WIDTH-1:0]     other_sum;
  logic [rmsa_pkg::OQ_WIDTH-1:0]             other_square_sum;

  modport source (
    output valid, action, sample_value, other_count, other_sum, other_square_sum,
    input  ready
  );

  modport sink (
    input  valid, action, sample_value, other_count, other_sum, other_square_sum,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/rmsa_out_if.sv =====
// Result request channel: valid/ready handshake with the statistics payload.
`default_nettype none

interface rmsa_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [rmsa_pkg::COUNT_WIDTH-1:0]        item_count;
  logic signed [rmsa_pkg::MEAN_WIDTH-1:0]  mean_q8;
  logic [rmsa_pkg::MEAN_WIDTH-1:0]         stdev_q8;
  logic                                    is_empty;
  logic                                    op_error;

  modport source (
    output valid, item_count, mean_q8, stdev_q8, is_empty, op_error,
    input  ready
  );

  modport sink (
    input  valid, item_count, mean_q8, stdev_q8, is_empty, op_error,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/rmsa_ctrl.sv =====
// Sequencer that steps the datapath through update, divide, square root and output.
`default_nettype none
`include "running_mean_stdev_accumulator_top_assert.svh"

module rmsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rmsa_pkg::dp_sts_t sts,
  output rmsa_pkg::dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_VSUB,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [rmsa_pkg::CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Command decode from the current state
  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == ST_IDLE) && in_valid;
    cmd.update    = (state_r == ST_UPDATE);
    cmd.prep      = (state_r == ST_PREP);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.mean_fix  = (state_r == ST_MEAN);
    cmd.mul       = (state_r == ST_MUL);
    cmd.vsub      = (state_r == ST_VSUB);
    cmd.sqrt_step = (state_r == ST_SQRT);
    cmd.out_load  = (state_r == ST_DONE) && out_free;
  end

  // Next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (sts.empty) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
          cnt_nxt   = rmsa_pkg::CNT_WIDTH'(rmsa_pkg::DIV_CYCLES - 1);
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_MEAN;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_MEAN: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_VSUB;
      end
      ST_VSUB: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = rmsa_pkg::CNT_WIDTH'(rmsa_pkg::SQRT_CYCLES - 1);
      end
      ST_SQRT: begin
        if (cnt_r == '0) state_nxt = ST_DONE;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the sink takes the request
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RMSA_ASSERT_NXT(a_capture_to_prep, cmd.capture, ##1 (state_r == ST_PREP), "accepted request did not reach prep")
  `RMSA_ASSERT_NXT(a_div_count_down, (state_r == ST_DIV) && (cnt_r != '0), (state_r == ST_DIV) && (cnt_r == $past(cnt_r) - 1'b1), "divide counter skipped")
  `RMSA_ASSERT_NXT(a_sqrt_entry, state_r == ST_VSUB, (state_r == ST_SQRT) && (cnt_r == rmsa_pkg::CNT_WIDTH'(rmsa_pkg::SQRT_CYCLES - 1)), "square root entered with wrong count")

endmodule

`default_nettype wire

// ===== hw/rtl/rmsa_dp.sv =====
// Datapath: running totals, two radix-4 dividers, square root unit and result register.
`default_nettype none
`include "running_mean_stdev_accumulator_top_assert.svh"

module rmsa_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire rmsa_pkg::dp_cmd_t                        cmd,
  output rmsa_pkg::dp_sts_t                             sts,
  input  wire logic [rmsa_pkg::ACT_WIDTH-1:0]           in_action,
  input  wire logic signed [rmsa_pkg::SAMPLE_WIDTH-1:0] in_sample_value,
  input  wire logic [rmsa_pkg::COUNT_WIDTH-1:0]         in_other_count,
  input  wire logic signed [rmsa_pkg::SUM_WIDTH-1:0]    in_other_sum,
  input  wire logic [rmsa_pkg::OQ_WIDTH-1:0]            in_other_square_sum,
  output logic [rmsa_pkg::COUNT_WIDTH-1:0]              out_item_count,
  output logic signed [rmsa_pkg::MEAN_WIDTH-1:0]        out_mean_q8,
  output logic [rmsa_pkg::MEAN_WIDTH-1:0]               out_stdev_q8,
  output logic                                          out_is_empty,
  output logic                                          out_op_error
);

  localparam int CW = rmsa_pkg::COUNT_WIDTH;
  localparam int SW = rmsa_pkg::SUM_WIDTH;
  localparam int QW = rmsa_pkg::SQ_WIDTH;
  localparam int NW = rmsa_pkg::DIVN_WIDTH;
  localparam int MW = rmsa_pkg::MEAN_WIDTH;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [NW-1:0] num;
  } div_t;

  // Restoring long division, DIV_RADIX_BITS quotient bits per call
  function automatic div_t div_step(div_t cur, logic [CW-1:0] d);
    div_t        r;
    logic [CW:0] t;
    r = cur;
    for (int k = 0; k < rmsa_pkg::DIV_RADIX_BITS; k++) begin
      t = {r.rem, r.num[NW-1]};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.num = {r.num[NW-2:0], 1'b1};
      end else begin
        r.num = {r.num[NW-2:0], 1'b0};
      end
      r.rem = t[CW-1:0];
    end
    return r;
  endfunction

  // Captured request
  rmsa_pkg::action_t                 act_r;
  logic signed [rmsa_pkg::SAMPLE_WIDTH-1:0] sample_r;
  logic [rmsa_pkg::VSQ_WIDTH-1:0]    vsq_r;
  logic [CW-1:0]                     oc_r;
  logic signed [SW-1:0]              os_r;
  logic [rmsa_pkg::OQ_WIDTH-1:0]     oq_r;
  logic signed [rmsa_pkg::VSQ_WIDTH-1:0] prod;

  // Running totals
  logic [CW-1:0]        count_r, count_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0]        sq_r, sq_nxt;
  logic                 err_r, err_nxt;
  logic [CW:0]          merge_sum;
  logic signed [SW-1:0] sample_ext;

  // Division, mean, variance and root
  div_t                 mdiv_r, vdiv_r;
  logic                 neg_r;
  logic [SW-1:0]        mag;
  logic [MW-1:0]        mm_r;
  logic signed [MW-1:0] mean_r;
  logic [MW-1:0]        lim;
  logic                 mean_over;
  logic [MW-1:0]        mm_nxt;
  logic [rmsa_pkg::MSQ_WIDTH-1:0] msq_r;
  logic [NW-1:0]        msq_ext;
  logic [NW-1:0]        sx_r, sres_r, sbit_r;
  logic [NW-1:0]        sq_trial;
  logic                 sq_take;
  logic [MW-1:0]        stdev_sat;

  assign sts.empty = (count_r == '0);

  assign prod       = rmsa_pkg::VSQ_WIDTH'(in_sample_value) *
                      rmsa_pkg::VSQ_WIDTH'(in_sample_value);
  assign sample_ext = SW'(sample_r);
  assign merge_sum  = {1'b0, count_r} + {1'b0, oc_r};

  // Totals update with count range check
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    err_nxt   = 1'b0;
    case (act_r)
      rmsa_pkg::ACT_ADD: begin
        if (count_r == '1) begin
          err_nxt = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_r + sample_ext;
          sq_nxt    = sq_r + QW'(vsq_r);
        end
      end
      rmsa_pkg::ACT_DROP: begin
        if (count_r == '0) begin
          err_nxt = 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          sum_nxt   = sum_r - sample_ext;
          sq_nxt    = sq_r - QW'(vsq_r);
        end
      end
      rmsa_pkg::ACT_MERGE: begin
        if (merge_sum[CW]) begin
          err_nxt = 1'b1;
        end else begin
          count_nxt = merge_sum[CW-1:0];
          sum_nxt   = sum_r + os_r;
          sq_nxt    = sq_r + QW'(oq_r);
        end
      end
      rmsa_pkg::ACT_EXCLUDE: begin
        if (oc_r > count_r) begin
          err_nxt = 1'b1;
        end else begin
          count_nxt = count_r - oc_r;
          sum_nxt   = sum_r - os_r;
          sq_nxt    = sq_r - QW'(oq_r);
        end
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  // Magnitude of the sum for the mean divide
  assign mag = sum_r[SW-1] ? (~sum_r + 1'b1) : sum_r;

  // Mean saturation against the signed range
  assign lim       = neg_r ? rmsa_pkg::MEAN_NEG_MAG : rmsa_pkg::MEAN_POS_MAX;
  assign mean_over = (|mdiv_r.num[NW-1:MW]) || (mdiv_r.num[MW-1:0] > lim);
  assign mm_nxt    = mean_over ? lim : mdiv_r.num[MW-1:0];

  // Square root trial: res and bit never overlap, so OR is the sum
  assign msq_ext  = NW'(msq_r);
  assign sq_trial = sres_r | sbit_r;
  assign sq_take  = (sx_r >= sq_trial);

  assign stdev_sat = (|sres_r[NW-1:MW]) ? rmsa_pkg::STDEV_MAX : sres_r[MW-1:0];

  // Totals and error flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      err_r   <= 1'b0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      err_r   <= err_nxt;
    end
  end

  // Request capture and arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= rmsa_pkg::action_t'(in_action);
      sample_r <= in_sample_value;
      vsq_r    <= unsigned'(prod);
      oc_r     <= in_other_count;
      os_r     <= in_other_sum;
      oq_r     <= in_other_square_sum;
    end
    if (cmd.prep) begin
      neg_r      <= sum_r[SW-1];
      mdiv_r.rem <= '0;
      mdiv_r.num <= NW'(mag) << rmsa_pkg::FRAC_BITS;
      vdiv_r.rem <= '0;
      vdiv_r.num <= NW'(sq_r) << (2 * rmsa_pkg::FRAC_BITS);
    end
    if (cmd.div_step) begin
      mdiv_r <= div_step(mdiv_r, count_r);
      vdiv_r <= div_step(vdiv_r, count_r);
    end
    if (cmd.mean_fix) begin
      mm_r   <= mm_nxt;
      mean_r <= neg_r ? signed'(~mm_nxt + 1'b1) : signed'(mm_nxt);
    end
    if (cmd.mul) begin
      msq_r <= rmsa_pkg::MSQ_WIDTH'(mm_r) * rmsa_pkg::MSQ_WIDTH'(mm_r);
    end
    if (cmd.vsub) begin
      sx_r   <= (vdiv_r.num >= msq_ext) ? (vdiv_r.num - msq_ext) : '0;
      sres_r <= '0;
      sbit_r <= rmsa_pkg::SQRT_BIT_INIT;
    end
    if (cmd.sqrt_step) begin
      if (sq_take) begin
        sx_r   <= sx_r - sq_trial;
        sres_r <= (sres_r >> 1) | sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.out_load) begin
      out_item_count <= count_r;
      out_is_empty   <= sts.empty;
      out_op_error   <= err_r;
      out_mean_q8    <= sts.empty ? '0 : mean_r;
      out_stdev_q8   <= sts.empty ? '0 : stdev_sat;
    end
  end

  `RMSA_ASSERT_NXT(a_reject_keeps_state, cmd.update, !err_r || ((count_r == $past(count_r)) && (sum_r == $past(sum_r)) && (sq_r == $past(sq_r))), "rejected request changed totals")
  `RMSA_ASSERT_NXT(a_mean_in_range, cmd.mean_fix, mm_r <= rmsa_pkg::MEAN_NEG_MAG, "mean magnitude out of range")
  `RMSA_ASSERT_NXT(a_empty_flag, cmd.out_load, out_is_empty == (out_item_count == '0), "empty flag disagrees with count")

endmodule

`default_nettype wire

// ===== hw/rtl/running_mean_stdev_accumulator_top.sv =====
// Top level of the running mean and standard deviation accumulator.
`default_nettype none

// Keeps count, sum and sum of squares of signed 16-bit samples and answers each
// request (add, drop, merge or exclude a set) with the count, the Q8 mean
// (truncated toward zero) and the Q8 population standard deviation (floor).
// One request is processed at a time. A non-empty set goes from accept to
// result through these steps: capture and update the totals, the mean and
// variance divides (two radix-4 restoring dividers running side by side on
// 80-bit scaled dividends), clip the mean, square it and subtract, the
// bit-serial square root, then load the result and return to idle. An empty
// set skips the divides and the root. A result waits in an output register;
// the next request is taken once the current one has been loaded there, and a
// full, untaken output register holds the block.
// Rejected requests (count overflow or underflow) leave the totals unchanged
// and set op_error.
module running_mean_stdev_accumulator_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmsa_in_if.sink     in_chan,
  rmsa_out_if.source  out_chan
);

  rmsa_pkg::dp_cmd_t cmd;
  rmsa_pkg::dp_sts_t sts;
  logic              in_ready;
  logic              out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  // Sequencer
  rmsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register
  rmsa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_chan.action),
    .in_sample_value     (in_chan.sample_value),
    .in_other_count      (in_chan.other_count),
    .in_other_sum        (in_chan.other_sum),
    .in_other_square_sum (in_chan.other_square_sum),
    .out_item_count      (out_chan.item_count),
    .out_mean_q8         (out_chan.mean_q8),
    .out_stdev_q8        (out_chan.stdev_q8),
    .out_is_empty        (out_chan.is_empty),
    .out_op_error        (out_chan.op_error)
  );

endmodule

`default_nettype wire

// ===== sim/rmsa_stats_checker.sv =====
// Result checker for the accumulator: tracks the totals, predicts every result and compares.
`timescale 1ns / 1ps

module rmsa_stats_checker
  import rmsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rmsa_in_if          in_mon,
  rmsa_out_if         out_mon,
  output int unsigned mismatch_total,
  output int unsigned results_open
);

  // One expected result
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [MEAN_WIDTH-1:0]  mean;
    logic [MEAN_WIDTH-1:0]  stdev;
    logic                   empty;
    logic                   rejected;
  } stats_t;

  // Mirror of the block's totals
  logic [COUNT_WIDTH-1:0] tot_count;
  logic [SUM_WIDTH-1:0]   tot_sum;
  logic [SQ_WIDTH-1:0]    tot_sq;

  stats_t      expected_stats[$];
  int unsigned mismatches;

  assign mismatch_total = mismatches;

  initial mismatches = 0;

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one request to the totals and work out the statistics it reports
  function automatic stats_t next_stats(action_t act, logic signed [SAMPLE_WIDTH-1:0] sample,
                                        logic [COUNT_WIDTH-1:0] oc, logic [SUM_WIDTH-1:0] os,
                                        logic [OQ_WIDTH-1:0] oq);
    logic signed [63:0]   v;
    logic [SUM_WIDTH-1:0] mag48;
    logic [127:0]         n, mag, quot, lim, mm, spread, msq, root, trial;
    logic                 neg, bad;
    int                   b;
    stats_t               r;

    v   = 64'(sample);
    bad = 1'b0;
    case (act)
      ACT_ADD: begin
        if (tot_count == {COUNT_WIDTH{1'b1}}) bad = 1'b1;
        else begin
          tot_count = tot_count + 1'b1;
          tot_sum   = tot_sum + v[SUM_WIDTH-1:0];
          tot_sq    = tot_sq + v * v;
        end
      end
      ACT_DROP: begin
        if (tot_count == '0) bad = 1'b1;
        else begin
          tot_count = tot_count - 1'b1;
          tot_sum   = tot_sum - v[SUM_WIDTH-1:0];
          tot_sq    = tot_sq - v * v;
        end
      end
      ACT_MERGE: begin
        if ({1'b0, tot_count} + {1'b0, oc} > {1'b0, {COUNT_WIDTH{1'b1}}}) bad = 1'b1;
        else begin
          tot_count = tot_count + oc;
          tot_sum   = tot_sum + os;
          tot_sq    = tot_sq + {1'b0, oq};
        end
      end
      default: begin
        if (oc > tot_count) bad = 1'b1;
        else begin
          tot_count = tot_count - oc;
          tot_sum   = tot_sum - os;
          tot_sq    = tot_sq - {1'b0, oq};
        end
      end
    endcase

    r          = '0;
    r.count    = tot_count;
    r.rejected = bad;
    r.empty    = (tot_count == '0);
    if (tot_count != '0) begin
      n = 128'(tot_count);

      // mean: magnitude divided, clipped to the signed range, sign restored
      neg   = tot_sum[SUM_WIDTH-1];
      mag48 = neg ? -tot_sum : tot_sum;
      mag   = 128'(mag48);
      quot  = (mag << FRAC_BITS) / n;
      lim   = (128'd1 << (MEAN_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
      mm    = (quot > lim) ? lim : quot;
      r.mean = neg ? -mm[MEAN_WIDTH-1:0] : mm[MEAN_WIDTH-1:0];

      // variance from the scaled square sum, clipped mean squared taken off
      spread = 128'(tot_sq);
      spread = (spread << (2 * FRAC_BITS)) / n;
      msq    = mm * mm;
      spread = (spread >= msq) ? spread - msq : '0;

      // floor square root, one bit at a time
      root = '0;
      for (b = 39; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= spread) root = trial;
      end
      r.stdev = (root > STDEV_MAX) ? STDEV_MAX : root[MEAN_WIDTH-1:0];
    end
    return r;
  endfunction

  // Results are compared before the request of the same edge is queued
  always @(posedge clk) begin
    stats_t want;
    if (!rst_n) begin
      tot_count = '0;
      tot_sum   = '0;
      tot_sq    = '0;
      expected_stats.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_stats.size() == 0) begin
          flag_mismatch("unexpected result, count", 64'(out_mon.item_count), '0);
        end else begin
          want = expected_stats.pop_front();
          if (out_mon.item_count !== want.count)
            flag_mismatch("item_count", 64'(out_mon.item_count), 64'(want.count));
          if (out_mon.mean_q8 !== want.mean)
            flag_mismatch("mean_q8", 64'($unsigned(out_mon.mean_q8)), 64'(want.mean));
          if (out_mon.stdev_q8 !== want.stdev)
            flag_mismatch("stdev_q8", 64'(out_mon.stdev_q8), 64'(want.stdev));
          if (out_mon.is_empty !== want.empty)
            flag_mismatch("is_empty", 64'(out_mon.is_empty), 64'(want.empty));
          if (out_mon.op_error !== want.rejected)
            flag_mismatch("op_error", 64'(out_mon.op_error), 64'(want.rejected));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_stats.push_back(next_stats(action_t'(in_mon.action), in_mon.sample_value,
                                            in_mon.other_count, in_mon.other_sum,
                                            in_mon.other_square_sum));
    end
    results_open <= expected_stats.size();
  end

endmodule

// ===== sim/running_mean_stdev_accumulator_top_test.sv =====
// Testbench top for the accumulator: clock, reset, request stimulus, result sink and verdict.
`timescale 1ns / 1ps

module running_mean_stdev_accumulator_top_test;
  import rmsa_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STEADY_FROM  = 300;
  localparam int STEADY_TO    = 500;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  // Slowest gap between accepts: hold-off + one full pass + sender gap
  localparam int STALL_LIMIT  = 4000;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [OQ_WIDTH-1:0]  SQ_MAX  = {OQ_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [SUM_WIDTH-1:0]   sum;
    logic [SQ_WIDTH-1:0]    sq;
  } sample_set_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  bit   hold_go;

  int unsigned mismatch_total;
  int unsigned results_open;

  // Totals as the stimulus side sees them, used to build well-formed requests
  logic [COUNT_WIDTH-1:0] held_count;
  logic [SUM_WIDTH-1:0]   held_sum;
  logic [SQ_WIDTH-1:0]    held_sq;
  logic signed [SAMPLE_WIDTH-1:0] added_q[$];
  sample_set_t merged_q[$];

  rmsa_in_if  in_chan();
  rmsa_out_if out_chan();

  running_mean_stdev_accumulator_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rmsa_stats_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_total (mismatch_total),
    .results_open   (results_open)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2: return '0;
      3, 4, 5: return SAMPLE_WIDTH'($urandom_range(511)) - SAMPLE_WIDTH'(256);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Offer one request, wait for it to be taken, then maybe leave a gap
  task automatic send_request(action_t act, logic signed [SAMPLE_WIDTH-1:0] sample,
                              logic [COUNT_WIDTH-1:0] oc, logic [SUM_WIDTH-1:0] os,
                              logic [OQ_WIDTH-1:0] oq);
    int gap;
    logic signed [63:0] sv;

    in_chan.valid            <= 1'b1;
    in_chan.action           <= act;
    in_chan.sample_value     <= sample;
    in_chan.other_count      <= oc;
    in_chan.other_sum        <= os;
    in_chan.other_square_sum <= oq;
    do @(posedge clk); while (!in_chan.ready);

    sv = 64'(sample);
    case (act)
      ACT_ADD: if (held_count != COUNT_FULL) begin
        held_count = held_count + 1'b1;
        held_sum   = held_sum + sv[SUM_WIDTH-1:0];
        held_sq    = held_sq + sv * sv;
      end
      ACT_DROP: if (held_count != '0) begin
        held_count = held_count - 1'b1;
        held_sum   = held_sum - sv[SUM_WIDTH-1:0];
        held_sq    = held_sq - sv * sv;
      end
      ACT_MERGE: if ({1'b0, held_count} + {1'b0, oc} <= {1'b0, COUNT_FULL}) begin
        held_count = held_count + oc;
        held_sum   = held_sum + os;
        held_sq    = held_sq + {1'b0, oq};
      end
      default: if (oc <= held_count) begin
        held_count = held_count - oc;
        held_sum   = held_sum - os;
        held_sq    = held_sq - {1'b0, oq};
      end
    endcase

    if (!steady && $urandom_range(99) < 30) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 4);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Take out everything held so the count and sum return to zero
  task automatic clear_totals();
    send_request(ACT_EXCLUDE, rand_sample(), held_count, held_sum, held_sq[OQ_WIDTH-1:0]);
    added_q.delete();
    merged_q.delete();
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    bit held_off;
    held_off = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held_off) begin
        held_off = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_chan.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog: too long without any request moving on either channel
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Request side and verdict
  initial begin : request_source
    int pick, k, idx;
    logic signed [SAMPLE_WIDTH-1:0] s;
    logic signed [63:0] sv;
    logic [COUNT_WIDTH-1:0] oc;
    sample_set_t grp;

    steady     = 1'b0;
    hold_go    = 1'b0;
    held_count = '0;
    held_sum   = '0;
    held_sq    = '0;
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.action           <= ACT_ADD;
    in_chan.sample_value     <= '0;
    in_chan.other_count      <= '0;
    in_chan.other_sum        <= '0;
    in_chan.other_square_sum <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty set, underflow, extremes, clipping, wrap, overflow
    send_request(ACT_DROP, 16'sd1, '0, '0, '0);
    send_request(ACT_EXCLUDE, '0, 32'd1, '0, '0);
    send_request(ACT_EXCLUDE, '0, '0, '0, '0);
    send_request(ACT_MERGE, '0, '0, '0, '0);
    send_request(ACT_ADD, 16'sh7FFF, '0, '0, '0);
    send_request(ACT_ADD, 16'sh8000, '0, '0, '0);
    send_request(ACT_ADD, '0, '0, '0, '0);
    send_request(ACT_ADD, -16'sd1, '0, '0, '0);
    send_request(ACT_DROP, 16'sh7FFF, '0, '0, '0);
    send_request(ACT_DROP, 16'sh8000, '0, '0, '0);
    // dropping a value never added wraps the square sum
    send_request(ACT_DROP, 16'sh8000, '0, '0, '0);
    send_request(ACT_ADD, 16'sh8000, '0, '0, '0);
    // mean clips high, deviation clips
    send_request(ACT_MERGE, '0, 32'd1, SUM_MAX, SQ_MAX);
    send_request(ACT_EXCLUDE, '0, 32'd1, SUM_MAX, SQ_MAX);
    // mean clips low
    send_request(ACT_MERGE, '0, 32'd1, SUM_MIN, '0);
    send_request(ACT_EXCLUDE, '0, 32'd1, SUM_MIN, '0);
    // both sums wrap, then come back
    send_request(ACT_EXCLUDE, '0, '0, SUM_MIN, SQ_MAX);
    send_request(ACT_MERGE, '0, '0, SUM_MIN, SQ_MAX);
    // variance below the mean squared clips to zero
    send_request(ACT_MERGE, '0, 32'd100, 48'd100, '0);
    // count overflow
    send_request(ACT_MERGE, '0, COUNT_FULL, '0, '0);
    send_request(ACT_MERGE, '0, COUNT_FULL - held_count, '0, '0);
    send_request(ACT_ADD, 16'sh7FFF, '0, '0, '0);
    send_request(ACT_MERGE, '0, 32'd1, '0, '0);
    send_request(ACT_DROP, 16'sd7, '0, '0, '0);
    send_request(ACT_ADD, 16'sd7, '0, '0, '0);
    clear_totals();

    // Random: mostly consistent samples and sets, some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= STEADY_FROM && i < STEADY_TO);
      if (i == HOLD_AT) hold_go = 1'b1;
      pick = $urandom_range(99);
      if (pick < 40) begin
        s = rand_sample();
        send_request(ACT_ADD, s, $urandom, SUM_WIDTH'({$urandom, $urandom}),
                     OQ_WIDTH'({$urandom, $urandom}));
        if (added_q.size() < 256) added_q.push_back(s);
      end else if (pick < 55 && added_q.size() > 0) begin
        idx = $urandom_range(added_q.size() - 1);
        s = added_q[idx];
        added_q.delete(idx);
        send_request(ACT_DROP, s, $urandom, SUM_WIDTH'({$urandom, $urandom}),
                     OQ_WIDTH'({$urandom, $urandom}));
      end else if (pick < 70) begin
        grp = '0;
        k = $urandom_range(1, 12);
        repeat (k) begin
          s  = rand_sample();
          sv = 64'(s);
          grp.count = grp.count + 1'b1;
          grp.sum   = grp.sum + sv[SUM_WIDTH-1:0];
          grp.sq    = grp.sq + sv * sv;
        end
        send_request(ACT_MERGE, rand_sample(), grp.count, grp.sum, grp.sq[OQ_WIDTH-1:0]);
        if (merged_q.size() < 16) merged_q.push_back(grp);
      end else if (pick < 80 && merged_q.size() > 0) begin
        idx = $urandom_range(merged_q.size() - 1);
        grp = merged_q[idx];
        merged_q.delete(idx);
        send_request(ACT_EXCLUDE, rand_sample(), grp.count, grp.sum, grp.sq[OQ_WIDTH-1:0]);
      end else if (pick < 84) begin
        clear_totals();
      end else begin
        // noise: random fields, counts near the overflow and underflow edges
        case ($urandom_range(3))
          0: oc = $urandom;
          1: oc = $urandom_range(4);
          2: oc = held_count + $urandom_range(1);
          default: oc = COUNT_FULL - held_count + $urandom_range(1);
        endcase
        send_request(action_t'($urandom_range(3)), SAMPLE_WIDTH'($urandom), oc,
                     SUM_WIDTH'({$urandom, $urandom}), OQ_WIDTH'({$urandom, $urandom}));
      end
    end
    steady = 1'b0;
    in_chan.valid <= 1'b0;

    // Wait for the last results, then a little longer for strays
    @(posedge clk);
    while (results_open != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && results_open == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rmsa_pkg.sv
hw/rtl/rmsa_in_if.sv
hw/rtl/rmsa_out_if.sv
hw/rtl/rmsa_ctrl.sv
hw/rtl/rmsa_dp.sv
hw/rtl/running_mean_stdev_accumulator_top.sv
sim/rmsa_stats_checker.sv
sim/running_mean_stdev_accumulator_top_test.sv
